### hdl/csq_pkg.sv
// Shared codes for the cross-section point query block: register indexes and shape modes.
package csq_pkg;

	// Configuration register indexes on the write port.
	typedef enum logic [2:0] {
		CFG_SHAPE_MODE = 3'd0,
		CFG_RADIUS     = 3'd1,
		CFG_CENTER_X   = 3'd2,
		CFG_CENTER_Y   = 3'd3,
		CFG_WIDTH      = 3'd4,
		CFG_HEIGHT     = 3'd5
	} cfg_idx_t;

	// Shape selector codes held in the shape_mode register.
	typedef enum logic [1:0] {
		SHAPE_CIRCLE = 2'd0,
		SHAPE_RECT   = 2'd1,
		SHAPE_ARCH   = 2'd2
	} shape_t;

	localparam int CFG_IDX_BITS = 3;

endpackage

### hdl/csq_isqrt.sv
// Pipelined floor square root, one result bit resolved per register stage.
module csq_isqrt #(
	parameter int RW = 34
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	localparam int RADW = 2 * RW;
	localparam int REMW = RW + 1;
	localparam int CURW = RW + 3;

	logic [REMW-1:0] rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [RADW-1:0] rest_s [RW];

	genvar i;
	generate
		for (i = 0; i < RW; i++) begin : g_stage
			logic [REMW-1:0] prev_rem;
			logic [RW-1:0]   prev_root;
			logic [RADW-1:0] prev_rest;
			logic [CURW-1:0] cur;
			logic [CURW-1:0] trial;
			logic            ge;

			// Stage inputs come from the port for the first stage, else from the prior stage.
			if (i == 0) begin : g_first
				assign prev_rem  = '0;
				assign prev_root = '0;
				assign prev_rest = rad;
			end else begin : g_next
				assign prev_rem  = rem_s[i-1];
				assign prev_root = root_s[i-1];
				assign prev_rest = rest_s[i-1];
			end

			// Bring down two radicand bits and try appending a one to the root.
			always_comb begin
				cur   = {prev_rem, prev_rest[RADW-1 -: 2]};
				trial = CURW'({prev_root, 2'b01});
				ge    = (cur >= trial);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i]  <= ge ? REMW'(cur - trial) : REMW'(cur);
					root_s[i] <= {prev_root[RW-2:0], ge};
					rest_s[i] <= prev_rest << 2;
				end
			end
		end
	endgenerate

	assign root = root_s[RW-1];

endmodule

### hdl/cross_section_point_query.sv
// Top level of the cross-section point query: inclusion test and boundary distance per point.
//
//  channel   | direction | contents
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | one query point per transaction (point_x, point_y)
//  m_axis    | out       | one result per transaction (inside_res, distance, valid)
//  cfg       | in        | register writes: shape_mode, radius, center_x/y, width, height
//
// One point is taken per cycle while the output does not stall. The depth from a taken point to
// its result is set by the three parallel square root pipelines, one stage per root bit.
// Reset clears the valid bits and loads the configuration reset values; no clearing pass.
// A stalled output holds the whole pipeline, except that empty slots ahead of the output
// register keep moving, so new points are taken while a result waits.
module cross_section_point_query #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [csq_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
	input  logic [COORD_BITS-1:0]                 cfg_wdata,
	// Point input: point_x, point_y.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// Result output: inside_res, boundary_distance, shape_valid.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((COORD_BITS+1+7)/8)*8-1:0]     m_axis_tdata
);

	localparam int CB   = COORD_BITS;
	localparam int UW   = CB - 1;
	localparam int XW   = CB + 3;
	localparam int MW   = CB + 1;
	localparam int SQW  = 2 * MW;
	localparam int SW   = SQW + 1;
	localparam int RW   = MW + 1;
	localparam int RADW = 2 * RW;
	localparam int ODW  = ((CB + 1 + 7) / 8) * 8;
	localparam logic [UW-1:0] ONE_FX  = UW'(64'd1 << FRAC_BITS);
	localparam logic [UW-1:0] DIST_MAX = '1;

	// Per-item side information carried along the pipeline.
	typedef struct packed {
		logic [1:0]    mode;
		logic          box;
		logic          straight;
		logic          below;
		logic          low_part;
		logic          hit;
		logic [RW-1:0] x2v;
		logic [RW-1:0] bv;
		logic [RW-1:0] y2v;
		logic [UW-1:0] rdist;
	} sb_t;

	// Configuration registers.
	logic [1:0]           shape_mode_q;
	logic [UW-1:0]        radius_q;
	logic signed [CB-1:0] center_x_q;
	logic signed [CB-1:0] center_y_q;
	logic [UW-1:0]        width_q;
	logic [UW-1:0]        height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode_q <= csq_pkg::SHAPE_CIRCLE;
			radius_q     <= ONE_FX;
			center_x_q   <= '0;
			center_y_q   <= '0;
			width_q      <= ONE_FX;
			height_q     <= ONE_FX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				csq_pkg::CFG_SHAPE_MODE: shape_mode_q <= cfg_wdata[1:0];
				csq_pkg::CFG_RADIUS:     radius_q     <= cfg_wdata[UW-1:0];
				csq_pkg::CFG_CENTER_X:   center_x_q   <= signed'(cfg_wdata);
				csq_pkg::CFG_CENTER_Y:   center_y_q   <= signed'(cfg_wdata);
				csq_pkg::CFG_WIDTH:      width_q      <= cfg_wdata[UW-1:0];
				csq_pkg::CFG_HEIGHT:     height_q     <= cfg_wdata[UW-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [MW-1:0] mag_f(input logic signed [XW-1:0] v);
		logic [XW-1:0] a;
		a = (v < 0) ? XW'(-v) : XW'(v);
		return a[MW-1:0];
	endfunction

	// Pipeline enable: the output register is free, being emptied, or has nothing to take.
	logic en;
	logic v_s1, v_s2, v_s3, v_f1;
	logic out_valid_q;
	logic [ODW-1:0] out_data_q;

	assign en            = !out_valid_q || m_axis_tready || !v_f1;
	assign s_axis_tready = en;

	// Stage 1: offsets, doubled arch coordinates, box test and rectangle distance.
	logic signed [XW-1:0] px, py, cxe, cye, we, he;
	logic signed [XW-1:0] dxc, dyc, x2, y2, w2, hw, ab, vv, sx, sy;
	logic signed [XW-1:0] rm0, rm1, rmin;
	logic                 circ_c, box_c;
	sb_t                  sb_c;
	logic [MW-1:0]        op_c [6];

	always_comb begin
		px  = XW'($signed(s_axis_tdata[CB-1:0]));
		py  = XW'($signed(s_axis_tdata[2*CB-1:CB]));
		cxe = XW'(center_x_q);
		cye = XW'(center_y_q);
		we  = signed'(XW'(width_q));
		he  = signed'(XW'(height_q));
		dxc = px - cxe;
		dyc = py - cye;
		x2  = px <<< 1;
		y2  = py <<< 1;
		w2  = we <<< 1;
		hw  = (he <<< 1) - we;
		ab  = w2 - x2;
		vv  = (hw > 0) ? (y2 - hw) : y2;
		sx  = x2 - we;
		sy  = y2 - hw;
		box_c  = (px >= 0) && (px <= we) && (py >= 0) && (py <= he);
		circ_c = (shape_mode_q == csq_pkg::SHAPE_CIRCLE);
		rm0  = (px < (we - px)) ? px : (we - px);
		rm1  = (py < (he - py)) ? py : (he - py);
		rmin = (rm0 < rm1) ? rm0 : rm1;

		sb_c.mode     = shape_mode_q;
		sb_c.box      = box_c;
		sb_c.straight = (hw > 0) && (y2 <= hw);
		sb_c.below    = (y2 < hw);
		sb_c.low_part = (y2 <= hw);
		sb_c.hit      = 1'b0;
		sb_c.x2v      = x2[RW-1:0];
		sb_c.bv       = ab[RW-1:0];
		sb_c.y2v      = y2[RW-1:0];
		sb_c.rdist    = rmin[UW-1:0];

		op_c[0] = circ_c ? mag_f(dxc) : mag_f(x2);
		op_c[1] = circ_c ? mag_f(dyc) : mag_f(vv);
		op_c[2] = mag_f(ab);
		op_c[3] = mag_f(vv);
		op_c[4] = mag_f(sx);
		op_c[5] = mag_f(sy);
	end

	sb_t           sb_s1, sb_s2, sb_s3, sb_f1;
	logic [MW-1:0] op_s1 [6];
	logic [SQW-1:0] sq_s2 [6];
	logic [2*UW-1:0] rsq_s2;
	logic [SW-1:0] sum_s3 [3];
	logic [UW-1:0] rsel;

	assign rsel = (sb_s1.mode == csq_pkg::SHAPE_CIRCLE) ? radius_q : width_q;

	// Stage 3 inclusion test: box test, and sum of squares against the squared radius (circle) or width (arch).
	logic inside_c;
	logic [SW-1:0] sum_c [3];
	sb_t           sb_c3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = SW'(sq_s2[2*k]) + SW'(sq_s2[2*k+1]);
		end
		case (sb_s2.mode)
			csq_pkg::SHAPE_CIRCLE: inside_c = (sum_c[0] <= SW'(rsq_s2));
			csq_pkg::SHAPE_RECT:   inside_c = sb_s2.box;
			csq_pkg::SHAPE_ARCH:   inside_c = sb_s2.box &&
				(sb_s2.low_part || (sum_c[2] <= SW'(rsq_s2)));
			default:               inside_c = 1'b0;
		endcase
		sb_c3     = sb_s2;
		sb_c3.hit = inside_c;
	end

	// Stages 1 to 3 payload: operands, squares, sums.
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= sb_c;
			for (int k = 0; k < 6; k++) begin
				op_s1[k] <= op_c[k];
				sq_s2[k] <= op_s1[k] * op_s1[k];
			end
			sb_s2  <= sb_s1;
			rsq_s2 <= rsel * rsel;
			for (int k = 0; k < 3; k++) begin
				sum_s3[k] <= sum_c[k];
			end
			sb_s3 <= sb_c3;
		end
	end

	// Square root units: circle or left wall, right wall, arc radial distance.
	logic [RW-1:0] root [3];

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_root
			csq_isqrt #(.RW(RW)) u_isqrt (
				.clk  (clk),
				.en   (en),
				.rad  (RADW'(sum_s3[g])),
				.root (root[g])
			);
		end
	endgenerate

	// Side information rides alongside the square root stages.
	sb_t  sb_sq [RW];
	logic v_sq  [RW];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sq[0] <= sb_s3;
			for (int k = 1; k < RW; k++) begin
				sb_sq[k] <= sb_sq[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_f1 <= 1'b0;
			for (int k = 0; k < RW; k++) begin
				v_sq[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= s_axis_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_sq[0] <= v_s3;
			for (int k = 1; k < RW; k++) begin
				v_sq[k] <= v_sq[k-1];
			end
			v_f1 <= v_sq[RW-1];
		end
	end

	// Final stage 1: circle distance, wall and arc terms.
	sb_t           sb_e;
	logic [RW-1:0] wext, radx;
	logic [UW-1:0] cdist_c, cdist_f1;
	logic [RW-1:0] lw_c, rw_c, arc_c, lw_f1, rw_f1, arc_f1;

	always_comb begin
		sb_e    = sb_sq[RW-1];
		wext    = RW'(width_q);
		radx    = RW'(radius_q);
		cdist_c = (root[0] < radx) ? UW'(radx - root[0]) : '0;
		lw_c    = sb_e.straight ? sb_e.x2v : root[0];
		rw_c    = sb_e.straight ? sb_e.bv  : root[1];
		if (sb_e.below) begin
			arc_c = (root[0] < root[1]) ? root[0] : root[1];
		end else begin
			arc_c = (root[2] < wext) ? (wext - root[2]) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_f1    <= sb_e;
			cdist_f1 <= cdist_c;
			lw_f1    <= lw_c;
			rw_f1    <= rw_c;
			arc_f1   <= arc_c;
		end
	end

	// Final stage 2: minimum of the arch terms, halving, saturation and shape validity.
	logic [RW-1:0] m0, m1, best;
	logic [RW-1:0] half;
	logic [UW-1:0] adist, dist_c;
	logic          svalid_c;
	logic [ODW-1:0] res_c;

	always_comb begin
		m0    = (sb_f1.y2v < lw_f1) ? sb_f1.y2v : lw_f1;
		m1    = (rw_f1 < arc_f1) ? rw_f1 : arc_f1;
		best  = (m0 < m1) ? m0 : m1;
		half  = best >> 1;
		adist = (half > RW'(DIST_MAX)) ? DIST_MAX : half[UW-1:0];
		case (sb_f1.mode)
			csq_pkg::SHAPE_CIRCLE: begin
				dist_c   = cdist_f1;
				svalid_c = (radius_q != '0);
			end
			csq_pkg::SHAPE_RECT: begin
				dist_c   = sb_f1.box ? sb_f1.rdist : '0;
				svalid_c = (width_q != '0) && (height_q != '0);
			end
			csq_pkg::SHAPE_ARCH: begin
				dist_c   = sb_f1.hit ? adist : '0;
				svalid_c = (width_q != '0) && ((CB'(height_q) << 1) >= CB'(width_q));
			end
			default: begin
				dist_c   = '0;
				svalid_c = 1'b0;
			end
		endcase
		res_c = ODW'({svalid_c, dist_c, sb_f1.hit});
	end

	// Output register: loads a finished result, empties on a completed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_f1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_f1) begin
			out_data_q <= res_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A nonzero distance only comes with a point that is inside.
	a_dist_implies_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[UW:1] != '0)) |-> m_axis_tdata[0])
		else $error("nonzero boundary distance on an outside point");

	// The unused shape code gives an all-zero result.
	a_unused_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (shape_mode_q != csq_pkg::SHAPE_CIRCLE)
			&& (shape_mode_q != csq_pkg::SHAPE_RECT)
			&& (shape_mode_q != csq_pkg::SHAPE_ARCH)) |-> (m_axis_tdata == '0))
		else $error("unused shape code gave a nonzero result");

	// A new result only appears when the last pipeline stage held a valid item.
	a_out_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_f1))
		else $error("output loaded from an empty pipeline stage");

endmodule
